>>> hw/rtl/quaternion_point_rotator_defines.svh
// Assertion macros shared by the quaternion point rotator RTL.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef QUATERNION_POINT_ROTATOR_DEFINES_SVH
`define QUATERNION_POINT_ROTATOR_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define QPR_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define QPR_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/qpr_pkg.sv
// Package of the quaternion point rotator: widths, register codes and item types.
// Used by qpr_coef, qpr_div and quaternion_point_rotator.
`default_nettype none

package qpr_pkg;

	// Field widths fixed by the item formats.
	localparam int COORD_W   = 32;  // Q16.16 point coordinate
	localparam int Q_W       = 32;  // Q2.30 quaternion component
	localparam int CFG_IDX_W = 4;   // configuration register index

	// Internal widths of the exact arithmetic.
	localparam int PQ_W   = 2 * Q_W;                 // product of two components
	localparam int M_W    = PQ_W + 2;                // rotation matrix entry, signed
	localparam int NORM_W = PQ_W + 1;                // squared norm, unsigned
	localparam int ML_W   = M_W / 2;                 // low slice of a matrix entry
	localparam int PPL_W  = ML_W + 1 + COORD_W;      // low partial product
	localparam int PPH_W  = (M_W - ML_W) + COORD_W;  // high partial product
	localparam int PROD_W = M_W + COORD_W;           // matrix entry times coordinate
	localparam int MAG_W  = PROD_W - 1;              // magnitude of a row sum
	localparam int QUO_W  = COORD_W;                 // quotient bits produced

	// Cycles from a register write until all derived coefficients are valid.
	localparam int COEF_LAT = 3;
	localparam int SETTLE_W = $clog2(COEF_LAT + 1);

	localparam logic [Q_W-1:0] QUAT_W_RESET = {2'b01, {(Q_W-2){1'b0}}};

	localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_QUAT_W = CFG_IDX_W'(0),
		REG_QUAT_X = CFG_IDX_W'(1),
		REG_QUAT_Y = CFG_IDX_W'(2),
		REG_QUAT_Z = CFG_IDX_W'(3)
	} cfg_reg_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
	} point_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] rotated_x;
		logic signed [COORD_W-1:0] rotated_y;
		logic signed [COORD_W-1:0] rotated_z;
		logic                      saturated_flag;
		logic                      degenerate_flag;
	} result_t;

	// Coefficients derived from the quaternion registers.
	typedef struct packed {
		logic [2:0][2:0][M_W-1:0] mat;        // unnormalized rotation matrix
		logic [NORM_W-1:0]        norm;       // w^2 + x^2 + y^2 + z^2
		logic [MAG_W-1:0]         lim_pos;    // norm * 2^31
		logic [MAG_W-1:0]         lim_neg;    // norm * (2^31 + 1)
		logic                     degenerate; // all components zero
		logic                     busy;       // coefficients still settling
	} coef_t;

	// One lane entering the divider.
	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic             neg;
		logic             sat;
	} div_lane_t;

	// One lane leaving the divider.
	typedef struct packed {
		logic [QUO_W-1:0] quo;
		logic             neg;
		logic             sat;
	} div_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/qpr_coef.sv
// Quaternion registers and the three-stage pipeline that derives the rotation
// matrix, squared norm and saturation limits from them. Depends on qpr_pkg.
`default_nettype none

module qpr_coef (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic [qpr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [qpr_pkg::Q_W-1:0]        cfg_data,
	output qpr_pkg::coef_t                 coef
);
	import qpr_pkg::*;

	logic signed [Q_W-1:0] quat_w_q, quat_x_q, quat_y_q, quat_z_q;
	logic [SETTLE_W-1:0]   settle_q;

	logic signed [PQ_W-1:0] ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [PQ_W-1:0] xy_s1, wz_s1, xz_s1, wy_s1, yz_s1, wx_s1;

	logic [2:0][2:0][M_W-1:0] mat_s2;
	logic [NORM_W-1:0]        norm_s2;
	logic [MAG_W-1:0]         lim_pos_s3, lim_neg_s3;

	// Register writes; an index past the last register is dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_w_q <= QUAT_W_RESET;
			quat_x_q <= '0;
			quat_y_q <= '0;
			quat_z_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_QUAT_W: quat_w_q <= cfg_data;
				REG_QUAT_X: quat_x_q <= cfg_data;
				REG_QUAT_Y: quat_y_q <= cfg_data;
				REG_QUAT_Z: quat_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Hold off new items until the derived coefficients have caught up.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			settle_q <= SETTLE_W'(COEF_LAT);
		end else if (cfg_valid) begin
			settle_q <= SETTLE_W'(COEF_LAT);
		end else if (settle_q != '0) begin
			settle_q <= settle_q - SETTLE_W'(1);
		end
	end

	// Stage 1: the ten component products.
	always_ff @(posedge clk) begin
		ww_s1 <= PQ_W'(quat_w_q) * PQ_W'(quat_w_q);
		xx_s1 <= PQ_W'(quat_x_q) * PQ_W'(quat_x_q);
		yy_s1 <= PQ_W'(quat_y_q) * PQ_W'(quat_y_q);
		zz_s1 <= PQ_W'(quat_z_q) * PQ_W'(quat_z_q);
		xy_s1 <= PQ_W'(quat_x_q) * PQ_W'(quat_y_q);
		wz_s1 <= PQ_W'(quat_w_q) * PQ_W'(quat_z_q);
		xz_s1 <= PQ_W'(quat_x_q) * PQ_W'(quat_z_q);
		wy_s1 <= PQ_W'(quat_w_q) * PQ_W'(quat_y_q);
		yz_s1 <= PQ_W'(quat_y_q) * PQ_W'(quat_z_q);
		wx_s1 <= PQ_W'(quat_w_q) * PQ_W'(quat_x_q);
	end

	// Stage 2: matrix entries and squared norm.
	always_ff @(posedge clk) begin
		mat_s2[0][0] <= M_W'(ww_s1) + M_W'(xx_s1) - M_W'(yy_s1) - M_W'(zz_s1);
		mat_s2[1][1] <= M_W'(ww_s1) + M_W'(yy_s1) - M_W'(xx_s1) - M_W'(zz_s1);
		mat_s2[2][2] <= M_W'(ww_s1) + M_W'(zz_s1) - M_W'(xx_s1) - M_W'(yy_s1);
		mat_s2[0][1] <= (M_W'(xy_s1) - M_W'(wz_s1)) <<< 1;
		mat_s2[1][0] <= (M_W'(xy_s1) + M_W'(wz_s1)) <<< 1;
		mat_s2[0][2] <= (M_W'(xz_s1) + M_W'(wy_s1)) <<< 1;
		mat_s2[2][0] <= (M_W'(xz_s1) - M_W'(wy_s1)) <<< 1;
		mat_s2[1][2] <= (M_W'(yz_s1) - M_W'(wx_s1)) <<< 1;
		mat_s2[2][1] <= (M_W'(yz_s1) + M_W'(wx_s1)) <<< 1;
		norm_s2      <= NORM_W'(ww_s1) + NORM_W'(xx_s1) + NORM_W'(yy_s1) + NORM_W'(zz_s1);
	end

	// Stage 3: thresholds at which a quotient leaves the output range.
	always_ff @(posedge clk) begin
		lim_pos_s3 <= MAG_W'(norm_s2) << (QUO_W - 1);
		lim_neg_s3 <= (MAG_W'(norm_s2) << (QUO_W - 1)) + MAG_W'(norm_s2);
	end

	assign coef.mat        = mat_s2;
	assign coef.norm       = norm_s2;
	assign coef.lim_pos    = lim_pos_s3;
	assign coef.lim_neg    = lim_neg_s3;
	assign coef.degenerate = (quat_w_q == '0) && (quat_x_q == '0) &&
	                         (quat_y_q == '0) && (quat_z_q == '0);
	assign coef.busy       = (settle_q != '0);

endmodule

`default_nettype wire

>>> hw/rtl/qpr_div.sv
// Pipelined restoring divider for three lanes: one quotient bit per stage,
// most significant first, against a shared divisor. Depends on qpr_pkg.
`default_nettype none

module qpr_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          in_valid,
	input  qpr_pkg::div_lane_t [2:0]      lanes_in,
	input  logic [qpr_pkg::NORM_W-1:0]    norm,
	output logic                          out_valid,
	output qpr_pkg::div_res_t [2:0]       lanes_out
);
	import qpr_pkg::*;

	logic                    v_s   [QUO_W];
	logic [2:0][MAG_W-1:0]   rem_s [QUO_W-1];
	logic [2:0][QUO_W-1:0]   quo_s [QUO_W];
	logic [2:0]              neg_s [QUO_W];
	logic [2:0]              sat_s [QUO_W];

	for (genvar j = 0; j < QUO_W; j++) begin : g_stage
		localparam int BIT = QUO_W - 1 - j;

		logic                  v_d;
		logic [2:0][MAG_W-1:0] rem_d, rem_n;
		logic [2:0][QUO_W-1:0] quo_d, quo_n;
		logic [2:0]            neg_d, sat_d;
		logic [MAG_W-1:0]      trial;

		// Stage inputs come from the ports at the head, else from the stage before.
		if (j == 0) begin : g_head
			assign v_d = in_valid;
			always_comb begin
				for (int l = 0; l < 3; l++) begin
					rem_d[l] = lanes_in[l].mag;
					quo_d[l] = '0;
					neg_d[l] = lanes_in[l].neg;
					sat_d[l] = lanes_in[l].sat;
				end
			end
		end else begin : g_body
			assign v_d   = v_s[j-1];
			assign rem_d = rem_s[j-1];
			assign quo_d = quo_s[j-1];
			assign neg_d = neg_s[j-1];
			assign sat_d = sat_s[j-1];
		end

		assign trial = {{(MAG_W-NORM_W){1'b0}}, norm} << BIT;

		// One compare and subtract per lane.
		always_comb begin
			for (int l = 0; l < 3; l++) begin
				if (rem_d[l] >= trial) begin
					rem_n[l] = rem_d[l] - trial;
					quo_n[l] = {quo_d[l][QUO_W-2:0], 1'b1};
				end else begin
					rem_n[l] = rem_d[l];
					quo_n[l] = {quo_d[l][QUO_W-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[j] <= 1'b0;
			end else if (en) begin
				v_s[j] <= v_d;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[j] <= quo_n;
				neg_s[j] <= neg_d;
				sat_s[j] <= sat_d;
			end
		end

		// The last stage needs no remainder.
		if (j < QUO_W - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[j] <= rem_n;
				end
			end
		end
	end

	assign out_valid = v_s[QUO_W-1];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			lanes_out[l].quo = quo_s[QUO_W-1][l];
			lanes_out[l].neg = neg_s[QUO_W-1][l];
			lanes_out[l].sat = sat_s[QUO_W-1][l];
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/quaternion_point_rotator.sv
// Top level of the quaternion point rotator: input stages, matrix product,
// magnitude and range check, divider and output buffer. Depends on qpr_pkg,
// qpr_coef, qpr_div and quaternion_point_rotator_defines.svh.
//
// Usage: points arrive on in_valid/in_ready/in_data, rotated points leave on
// out_valid/out_ready/out_data, and the quaternion is written on
// cfg_valid/cfg_ready/cfg_index/cfg_data (index 0..3 = w, x, y, z; others
// are ignored). cfg_ready is always high; write only while no item is in flight.
// Throughput is one item per cycle while in_ready is high. An accepted point passes
// through seven stages of point register, multiply, sum, magnitude and range check,
// 32 divider stages (one quotient bit each) and the output register behind out_valid.
// After reset and after every register write, in_ready stays low while the matrix,
// norm and limit pipeline refills. Reset loads the identity quaternion and empties
// the pipeline.
// When the receiver stalls, one more item is caught in a skid register and the
// whole pipeline then holds; in_ready follows from registered state only.
`default_nettype none
`include "quaternion_point_rotator_defines.svh"

module quaternion_point_rotator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  qpr_pkg::point_t                in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output qpr_pkg::result_t               out_data,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [qpr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [qpr_pkg::Q_W-1:0]        cfg_data
);
	import qpr_pkg::*;

	coef_t coef;
	logic  en;

	logic                      v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic signed [COORD_W-1:0] pt_s1    [3];
	logic signed [PPL_W-1:0]   pp_lo_s2 [3][3];
	logic signed [PPH_W-1:0]   pp_hi_s2 [3][3];
	logic signed [PROD_W-1:0]  prod_s3  [3][3];
	logic signed [PROD_W-1:0]  pair_s4  [3];
	logic signed [PROD_W-1:0]  third_s4 [3];
	logic signed [PROD_W-1:0]  acc_s5   [3];
	logic [MAG_W-1:0]          mag_s6   [3];
	logic [MAG_W-1:0]          mag_s7   [3];
	logic [2:0]                neg_s6, neg_s7, sat_s7;

	div_lane_t [2:0] div_in;
	div_res_t  [2:0] div_out;
	logic            div_valid;

	logic [COORD_W-1:0] res_val [3];
	result_t            res_d;
	logic               push;

	result_t out_data_q, skid_data_q;
	logic    out_valid_q, skid_valid_q;

	// Coefficients from the quaternion registers.
	qpr_coef u_coef (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coef      (coef)
	);

	assign cfg_ready = 1'b1;

	// The pipeline moves whenever the skid register is free.
	assign en       = !skid_valid_q;
	assign in_ready = en && !coef.busy;

	// Valid bits of the front stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid && !coef.busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Stage 1: register the point.
	always_ff @(posedge clk) begin
		if (en) begin
			pt_s1[0] <= in_data.point_x;
			pt_s1[1] <= in_data.point_y;
			pt_s1[2] <= in_data.point_z;
		end
	end

	// Stage 2: each matrix entry times a coordinate, split into two products.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					pp_lo_s2[i][k] <= PPL_W'($signed({1'b0, coef.mat[i][k][ML_W-1:0]})) *
					                  PPL_W'(pt_s1[k]);
					pp_hi_s2[i][k] <= PPH_W'($signed(coef.mat[i][k][M_W-1:ML_W])) *
					                  PPH_W'(pt_s1[k]);
				end
			end
		end
	end

	// Stage 3: join the two halves of every product.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s3[i][k] <= (PROD_W'(pp_hi_s2[i][k]) <<< ML_W) +
					                 PROD_W'(pp_lo_s2[i][k]);
				end
			end
		end
	end

	// Stages 4 and 5: sum the three products of each row.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				pair_s4[i]  <= prod_s3[i][0] + prod_s3[i][1];
				third_s4[i] <= prod_s3[i][2];
				acc_s5[i]   <= pair_s4[i] + third_s4[i];
			end
		end
	end

	// Stage 6: sign and magnitude of each row sum.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s6[i] <= acc_s5[i][PROD_W-1];
				mag_s6[i] <= acc_s5[i][PROD_W-1] ? MAG_W'(-acc_s5[i]) : MAG_W'(acc_s5[i]);
			end
		end
	end

	// Stage 7: decide saturation before dividing; a quotient that stays in
	// range then fits in the divider's 32 bits.
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				neg_s7[i] <= neg_s6[i];
				mag_s7[i] <= mag_s6[i];
				sat_s7[i] <= neg_s6[i] ? (mag_s6[i] >= coef.lim_neg) :
				                         (mag_s6[i] >= coef.lim_pos);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			div_in[i].mag = mag_s7[i];
			div_in[i].neg = neg_s7[i];
			div_in[i].sat = sat_s7[i];
		end
	end

	qpr_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s7),
		.lanes_in  (div_in),
		.norm      (coef.norm),
		.out_valid (div_valid),
		.lanes_out (div_out)
	);

	// Apply sign and saturation; a zero quaternion forces a zero result.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (div_out[i].sat) begin
				res_val[i] = div_out[i].neg ? COORD_MIN : COORD_MAX;
			end else begin
				res_val[i] = div_out[i].neg ? -div_out[i].quo : div_out[i].quo;
			end
		end
		if (coef.degenerate) begin
			res_d.rotated_x       = '0;
			res_d.rotated_y       = '0;
			res_d.rotated_z       = '0;
			res_d.saturated_flag  = 1'b0;
			res_d.degenerate_flag = 1'b1;
		end else begin
			res_d.rotated_x       = res_val[0];
			res_d.rotated_y       = res_val[1];
			res_d.rotated_z       = res_val[2];
			res_d.saturated_flag  = div_out[0].sat || div_out[1].sat || div_out[2].sat;
			res_d.degenerate_flag = 1'b0;
		end
	end

	assign push = div_valid && en;

	// Output register with one skid entry behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_ready) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else if (push) begin
				out_data_q <= res_d;
			end
		end else if (push) begin
			skid_data_q <= res_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// The skid entry is only ever filled behind a waiting output item.
	`QPR_ASSERT_IMP(a_skid_behind_out, skid_valid_q, out_valid_q,
		"skid holds an item while the output register is empty")

	// A zero quaternion yields an all-zero result without the saturation flag.
	`QPR_ASSERT_IMP(a_degenerate_zero, out_valid && out_data.degenerate_flag,
		out_data.rotated_x == '0 && out_data.rotated_y == '0 &&
		out_data.rotated_z == '0 && !out_data.saturated_flag,
		"degenerate result is not zero")

	// A register write keeps new points out while the coefficients refill.
	`QPR_ASSERT_NXT(a_cfg_holds_input, cfg_valid && cfg_ready, !in_ready,
		"input accepted right after a register write")

endmodule

`default_nettype wire

>>> dv/quaternion_point_rotator_checker.sv
`timescale 1ns / 100ps
// Checker for the quaternion point rotator: watches the configuration, point and result
// channels, predicts each rotated point exactly and compares it. Depends on qpr_pkg.
module quaternion_point_rotator_checker
	import qpr_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  point_t                in_data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  result_t               out_data,
	input  logic                  cfg_valid,
	input  logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [Q_W-1:0]        cfg_data,
	output int                    fail_count,
	output int                    pending_count
);

	// Wide enough for every exact intermediate: products, matrix entries and row sums.
	typedef logic signed [127:0] wide_t;

	localparam wide_t COORD_HI = (wide_t'(1) <<< (COORD_W - 1)) - 1;
	localparam wide_t COORD_LO = -(wide_t'(1) <<< (COORD_W - 1));

	// Shadow copy of the quaternion registers.
	logic signed [Q_W-1:0] quat_w, quat_x, quat_y, quat_z;

	result_t expected_rotations [$];

	// Exact rotation: R(q) * v / |q|^2, truncated toward zero, then clipped to 32 bits.
	function automatic result_t rotate_point(input point_t p);
		wide_t w, x, y, z;
		wide_t w2, x2, y2, z2, xy, wz, xz, wy, yz, wx;
		wide_t mat [3][3];
		wide_t vec [3];
		wide_t norm, row_sum, quo;
		logic signed [COORD_W-1:0] coord [3];
		result_t r;
		r = '0;
		if (quat_w == 0 && quat_x == 0 && quat_y == 0 && quat_z == 0) begin
			r.degenerate_flag = 1'b1;
			return r;
		end
		w = quat_w;
		x = quat_x;
		y = quat_y;
		z = quat_z;
		vec[0] = p.point_x;
		vec[1] = p.point_y;
		vec[2] = p.point_z;
		w2 = w * w;
		x2 = x * x;
		y2 = y * y;
		z2 = z * z;
		xy = x * y;
		wz = w * z;
		xz = x * z;
		wy = w * y;
		yz = y * z;
		wx = w * x;
		norm = w2 + x2 + y2 + z2;
		mat[0][0] = (w2 + x2) - (y2 + z2);
		mat[1][1] = (w2 + y2) - (x2 + z2);
		mat[2][2] = (w2 + z2) - (x2 + y2);
		mat[0][1] = (xy - wz) <<< 1;
		mat[1][0] = (xy + wz) <<< 1;
		mat[0][2] = (xz + wy) <<< 1;
		mat[2][0] = (xz - wy) <<< 1;
		mat[1][2] = (yz - wx) <<< 1;
		mat[2][1] = (yz + wx) <<< 1;
		for (int i = 0; i < 3; i++) begin
			row_sum = mat[i][0] * vec[0] + mat[i][1] * vec[1] + mat[i][2] * vec[2];
			quo = row_sum / norm;
			if (quo > COORD_HI) begin
				coord[i] = COORD_MAX;
				r.saturated_flag = 1'b1;
			end else if (quo < COORD_LO) begin
				coord[i] = COORD_MIN;
				r.saturated_flag = 1'b1;
			end else begin
				coord[i] = quo[COORD_W-1:0];
			end
		end
		r.rotated_x = coord[0];
		r.rotated_y = coord[1];
		r.rotated_z = coord[2];
		return r;
	endfunction

	task automatic compare_field(input string field, input logic [COORD_W-1:0] want,
			input logic [COORD_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%08h, actual 0x%08h", field, want, got);
			fail_count++;
		end
	endtask

	// Track register writes, queue a prediction per accepted point, check each result.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_w = QUAT_W_RESET;
			quat_x = '0;
			quat_y = '0;
			quat_z = '0;
			expected_rotations.delete();
			pending_count <= 0;
		end else begin : watch
			result_t want;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_QUAT_W: quat_w = cfg_data;
					REG_QUAT_X: quat_x = cfg_data;
					REG_QUAT_Y: quat_y = cfg_data;
					REG_QUAT_Z: quat_z = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				expected_rotations.push_back(rotate_point(in_data));
			if (out_valid && out_ready) begin
				if (expected_rotations.size() == 0) begin
					$error("result item 0x%h arrived with no point outstanding", out_data);
					fail_count++;
				end else begin
					want = expected_rotations.pop_front();
					compare_field("rotated_x", want.rotated_x, out_data.rotated_x);
					compare_field("rotated_y", want.rotated_y, out_data.rotated_y);
					compare_field("rotated_z", want.rotated_z, out_data.rotated_z);
					compare_field("saturated_flag", COORD_W'(want.saturated_flag),
						COORD_W'(out_data.saturated_flag));
					compare_field("degenerate_flag", COORD_W'(want.degenerate_flag),
						COORD_W'(out_data.degenerate_flag));
				end
			end
			pending_count <= expected_rotations.size();
		end
	end

endmodule

>>> dv/quaternion_point_rotator_tb.sv
`timescale 1ns / 100ps
// Testbench top for the quaternion point rotator: clock, reset, point and register
// stimulus, result back-pressure and the verdict. Depends on qpr_pkg and the checker.
module quaternion_point_rotator_tb;
	import qpr_pkg::*;

	localparam int PIPE_LATENCY    = 39;
	localparam int HOLD_OFF_CYCLES = 160;
	localparam int RUN_LIMIT_NS    = 1000000;
	localparam int RANDOM_PHASES   = 10;

	// Quaternion of a 45 degree turn about z, close to unit length.
	localparam logic [Q_W-1:0] TURN45_W = 32'd992008094;
	localparam logic [Q_W-1:0] TURN45_Z = 32'd410903207;

	typedef enum int {
		QK_FULL, QK_NEAR_UNIT, QK_EXTREME, QK_TINY, QK_ZERO, QK_ONE_AXIS, QK_ALL_MIN, QK_ALL_MAX
	} quat_kind_t;

	typedef enum int {PK_FULL, PK_SMALL, PK_EXTREME} coord_kind_t;

	typedef enum int {RDY_ALWAYS, RDY_HALF, RDY_MOSTLY, RDY_RARELY} ready_mode_t;

	logic                  clk;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_ready;
	point_t                in_data;
	logic                  out_valid;
	logic                  out_ready;
	result_t               out_data;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [Q_W-1:0]        cfg_data;
	int                    fail_count;
	int                    pending_count;
	bit                    hold_off_req;
	bit                    hold_off_active;

	quaternion_point_rotator i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	quaternion_point_rotator_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_data       (in_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_data      (out_data),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	// Clock with a 2 ns period.
	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Run limit.
	initial begin
		#RUN_LIMIT_NS;
		$display("simulation failed");
		$finish;
	end

	// Corner values shared by points and quaternion components.
	function automatic logic [31:0] extreme_word();
		case ($urandom_range(5, 0))
			0: return COORD_MIN;
			1: return COORD_MAX;
			2: return 32'd0;
			3: return 32'd1;
			4: return 32'hFFFF_FFFF;
			default: return QUAT_W_RESET;
		endcase
	endfunction

	function automatic logic [COORD_W-1:0] random_coord(input coord_kind_t kind);
		case (kind)
			PK_SMALL: return $urandom_range(32'h001F_FFFF, 0) - 32'h0010_0000;
			PK_EXTREME: return extreme_word();
			default: return $urandom();
		endcase
	endfunction

	// Mostly whole points of one flavor, sometimes each coordinate picked on its own.
	function automatic point_t random_point();
		coord_kind_t kind;
		point_t p;
		kind = coord_kind_t'($urandom_range(PK_EXTREME, PK_FULL));
		if ($urandom_range(5, 0) == 0) begin
			p.point_x = random_coord(coord_kind_t'($urandom_range(PK_EXTREME, PK_FULL)));
			p.point_y = random_coord(coord_kind_t'($urandom_range(PK_EXTREME, PK_FULL)));
			p.point_z = random_coord(coord_kind_t'($urandom_range(PK_EXTREME, PK_FULL)));
		end else begin
			p.point_x = random_coord(kind);
			p.point_y = random_coord(kind);
			p.point_z = random_coord(kind);
		end
		return p;
	endfunction

	function automatic point_t directed_point(input int n);
		point_t p;
		case (n)
			0: p = '{32'sd0, 32'sd0, 32'sd0};
			1: p = '{COORD_MAX, COORD_MAX, COORD_MAX};
			2: p = '{COORD_MIN, COORD_MIN, COORD_MIN};
			3: p = '{COORD_MAX, COORD_MIN, 32'sd0};
			4: p = '{COORD_MIN, COORD_MAX, COORD_MAX};
			5: p = '{32'sd65536, 32'sd0, 32'sd0};
			6: p = '{32'sd0, -32'sd65536, 32'sd0};
			7: p = '{32'sd1, -32'sd1, 32'sd1};
			8: p = '{32'h5555_5555, 32'hAAAA_AAAA, 32'h0F0F_0F0F};
			default: p = '{COORD_MIN, 32'sd0, COORD_MAX};
		endcase
		return p;
	endfunction

	// Offer one point and hold it until it is taken.
	task automatic offer_point(input point_t p);
		@(negedge clk);
		in_valid <= 1'b1;
		in_data  <= p;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic idle_cycles(input int count);
		repeat (count) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
	endtask

	// Random points in bursts, with gaps left out while the receiver holds off.
	task automatic send_points(input int count);
		int burst_left;
		int k;
		burst_left = 0;
		for (k = 0; k < count; k++) begin
			if (burst_left == 0) begin
				if (!(hold_off_req || hold_off_active) && k > 0)
					idle_cycles($urandom_range(3, 0) == 0 ? $urandom_range(15, 1)
						: $urandom_range(2, 1));
				burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(80, 30)
					: $urandom_range(12, 1);
			end
			offer_point(random_point());
			burst_left--;
		end
		idle_cycles(1);
	endtask

	task automatic wait_drained();
		wait (pending_count == 0);
		repeat (2) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [Q_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Registers change only with nothing in flight.
	task automatic set_quaternion(input logic [Q_W-1:0] w, input logic [Q_W-1:0] x,
			input logic [Q_W-1:0] y, input logic [Q_W-1:0] z);
		wait_drained();
		if ($urandom_range(1, 0))
			write_reg(CFG_IDX_W'($urandom_range(2 ** CFG_IDX_W - 1, int'(REG_QUAT_Z) + 1)),
				$urandom());
		write_reg(REG_QUAT_W, w);
		write_reg(REG_QUAT_X, x);
		write_reg(REG_QUAT_Y, y);
		write_reg(REG_QUAT_Z, z);
	endtask

	task automatic random_quaternion(input quat_kind_t kind);
		logic [Q_W-1:0] c [4];
		int axis;
		axis = $urandom_range(3, 0);
		for (int i = 0; i < 4; i++) begin
			case (kind)
				QK_FULL: c[i] = $urandom();
				QK_NEAR_UNIT: c[i] = $urandom_range(32'h7FFF_FFFF, 0) - 32'h4000_0000;
				QK_EXTREME: c[i] = extreme_word();
				QK_TINY: c[i] = $urandom_range(4, 0) - 32'd2;
				QK_ONE_AXIS: c[i] = (i == axis) ? $urandom() : '0;
				QK_ALL_MIN: c[i] = COORD_MIN;
				QK_ALL_MAX: c[i] = COORD_MAX;
				default: c[i] = '0;
			endcase
		end
		set_quaternion(c[0], c[1], c[2], c[3]);
	endtask

	// Result back-pressure: segments of differing stall density, plus one long hold-off.
	initial begin : receiver
		int seg_len;
		ready_mode_t mode;
		out_ready = 1'b0;
		forever begin
			if (hold_off_req) begin
				hold_off_req    = 1'b0;
				hold_off_active = 1'b1;
				repeat (HOLD_OFF_CYCLES) begin
					@(negedge clk);
					out_ready <= 1'b0;
				end
				hold_off_active = 1'b0;
			end else begin
				seg_len = $urandom_range(40, 4);
				mode    = ready_mode_t'($urandom_range(RDY_RARELY, RDY_ALWAYS));
				repeat (seg_len) begin
					@(negedge clk);
					case (mode)
						RDY_ALWAYS: out_ready <= 1'b1;
						RDY_HALF:   out_ready <= $urandom_range(1, 0);
						RDY_MOSTLY: out_ready <= ($urandom_range(7, 0) != 0);
						default:    out_ready <= ($urandom_range(7, 0) == 0);
					endcase
				end
			end
		end
	end

	// Stimulus and verdict.
	initial begin : stimulus
		int ph;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Identity quaternion out of reset: every point must come back unchanged.
		for (int n = 0; n < 10; n++)
			offer_point(directed_point(n));
		idle_cycles(1);

		// Writes beyond the last register leave the quaternion alone.
		wait_drained();
		write_reg(CFG_IDX_W'(REG_QUAT_Z) + 1'b1, COORD_MAX);
		write_reg({CFG_IDX_W{1'b1}}, 32'h1234_5678);
		offer_point(directed_point(8));
		idle_cycles(1);

		// A 45 degree turn about z pushes the diagonal corners out of range.
		set_quaternion(TURN45_W, '0, '0, TURN45_Z);
		for (int n = 0; n < 10; n++)
			offer_point(directed_point(n));
		idle_cycles(1);

		// Zero quaternion gives zeros and the degenerate flag.
		set_quaternion('0, '0, '0, '0);
		offer_point(directed_point(1));
		offer_point(directed_point(2));
		idle_cycles(1);

		// Random phases, each with a fresh quaternion.
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph < 8)
				random_quaternion(quat_kind_t'(ph));
			else
				random_quaternion(quat_kind_t'($urandom_range(QK_ONE_AXIS, QK_FULL)));
			if (ph == 0) begin
				// Long receiver hold-off while points keep coming, so the input stalls.
				hold_off_req = 1'b1;
				send_points(90);
			end else if (ph == 2) begin
				send_points(20);
				wait_drained();
				send_points(20);
			end else begin
				send_points(40);
			end
		end

		wait_drained();
		repeat (PIPE_LATENCY + 10) @(negedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/qpr_pkg.sv
hw/rtl/qpr_coef.sv
hw/rtl/qpr_div.sv
hw/rtl/quaternion_point_rotator.sv
dv/quaternion_point_rotator_checker.sv
dv/quaternion_point_rotator_tb.sv
